// ----- design/pwlc_pkg.sv -----
// Shared types and constants for the pulse-width line codec.
package pwlc_pkg;

   localparam int DEFAULT_TX_DEPTH = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TICK_W     = 16;
   localparam int TRIM_W     = 8;
   localparam int LEVEL_W    = 4;

   localparam logic [CSR_IDX_W-1:0] REG_ZERO_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TOL_BELOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOL_ABOVE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_TOL  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TX_TRIM    = 3'd6;

   localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 16'd8;
   localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 16'd16;
   localparam logic [TICK_W-1:0] RESET_HIGH_RST = 16'd200;
   localparam logic [TICK_W-1:0] TOL_BELOW_RST  = 16'd2;
   localparam logic [TICK_W-1:0] TOL_ABOVE_RST  = 16'd8;
   localparam logic [TICK_W-1:0] RESET_TOL_RST  = 16'd6;
   localparam logic [TRIM_W-1:0] TX_TRIM_RST    = 8'd3;

   localparam logic [TICK_W-1:0] WIDTH_MAX = 16'hFFFF;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_ENQUEUE = 1'b1;

   localparam logic [1:0] SYM_ZERO  = 2'd0;
   localparam logic [1:0] SYM_ONE   = 2'd1;
   localparam logic [1:0] SYM_RESET = 2'd2;
   localparam logic [1:0] SYM_ERROR = 2'd3;

   typedef struct packed {
      logic              op;
      logic              line_in;
      logic [TICK_W-1:0] high_ticks;
      logic [TICK_W-1:0] low_ticks;
   } req_type;

   typedef struct packed {
      logic               line_out;
      logic               rx_valid;
      logic [1:0]         rx_symbol;
      logic [TICK_W-1:0]  pulse_width;
      logic               enqueue_accepted;
      logic               tx_busy;
      logic [LEVEL_W-1:0] queue_level;
   } rsp_type;

   // lo is floored at zero, hi keeps the carry
   typedef struct packed {
      logic [TICK_W-1:0] lo;
      logic [TICK_W:0]   hi;
   } window_type;

   typedef struct packed {
      window_type zero_win;
      window_type one_win;
      window_type reset_win;
   } bounds_type;

   typedef struct packed {
      logic               line_out;
      logic               accepted;
      logic               busy;
      logic [LEVEL_W-1:0] level;
   } tx_status_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        symbol;
      logic [TICK_W-1:0] width;
   } rx_result_type;

endpackage

// ----- design/pwlc_csr.sv -----
// Configuration registers and registered receive window bounds.
module pwlc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pwlc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pwlc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [pwlc_pkg::TRIM_W-1:0]        trim,
   output pwlc_pkg::bounds_type               bounds
);
   import pwlc_pkg::*;

   logic [TICK_W-1:0] zero_high_ff, zero_high_in;
   logic [TICK_W-1:0] one_high_ff, one_high_in;
   logic [TICK_W-1:0] reset_high_ff, reset_high_in;
   logic [TICK_W-1:0] tol_below_ff, tol_below_in;
   logic [TICK_W-1:0] tol_above_ff, tol_above_in;
   logic [TICK_W-1:0] reset_tol_ff, reset_tol_in;
   logic [TRIM_W-1:0] trim_ff, trim_in;
   bounds_type        bounds_ff, bounds_in;

   function automatic window_type make_window(input logic [TICK_W-1:0] nom,
                                              input logic [TICK_W-1:0] below,
                                              input logic [TICK_W-1:0] above);
      window_type w;
      w.lo = (nom > below) ? nom - below : '0;
      w.hi = {1'b0, nom} + {1'b0, above};
      return w;
   endfunction

   always_comb begin
      zero_high_in  = zero_high_ff;
      one_high_in   = one_high_ff;
      reset_high_in = reset_high_ff;
      tol_below_in  = tol_below_ff;
      tol_above_in  = tol_above_ff;
      reset_tol_in  = reset_tol_ff;
      trim_in       = trim_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ZERO_HIGH:  zero_high_in  = csr_wdata;
            REG_ONE_HIGH:   one_high_in   = csr_wdata;
            REG_RESET_HIGH: reset_high_in = csr_wdata;
            REG_TOL_BELOW:  tol_below_in  = csr_wdata;
            REG_TOL_ABOVE:  tol_above_in  = csr_wdata;
            REG_RESET_TOL:  reset_tol_in  = csr_wdata;
            REG_TX_TRIM:    trim_in       = csr_wdata[TRIM_W-1:0];
            default: ;
         endcase
      end
      // bounds follow the next register values so they never lag a write
      bounds_in.zero_win  = make_window(zero_high_in, tol_below_in, tol_above_in);
      bounds_in.one_win   = make_window(one_high_in, tol_below_in, tol_above_in);
      bounds_in.reset_win = make_window(reset_high_in, reset_tol_in, reset_tol_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff  <= ZERO_HIGH_RST;
         one_high_ff   <= ONE_HIGH_RST;
         reset_high_ff <= RESET_HIGH_RST;
         tol_below_ff  <= TOL_BELOW_RST;
         tol_above_ff  <= TOL_ABOVE_RST;
         reset_tol_ff  <= RESET_TOL_RST;
         trim_ff       <= TX_TRIM_RST;
         bounds_ff.zero_win  <= make_window(ZERO_HIGH_RST, TOL_BELOW_RST, TOL_ABOVE_RST);
         bounds_ff.one_win   <= make_window(ONE_HIGH_RST, TOL_BELOW_RST, TOL_ABOVE_RST);
         bounds_ff.reset_win <= make_window(RESET_HIGH_RST, RESET_TOL_RST, RESET_TOL_RST);
      end else begin
         zero_high_ff  <= zero_high_in;
         one_high_ff   <= one_high_in;
         reset_high_ff <= reset_high_in;
         tol_below_ff  <= tol_below_in;
         tol_above_ff  <= tol_above_in;
         reset_tol_ff  <= reset_tol_in;
         trim_ff       <= trim_in;
         bounds_ff     <= bounds_in;
      end
   end

   assign trim   = trim_ff;
   assign bounds = bounds_ff;

endmodule

// ----- design/pwlc_tx.sv -----
// Transmit pulse queue and line generator.
module pwlc_tx #(
   parameter int TX_DEPTH = pwlc_pkg::DEFAULT_TX_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  pwlc_pkg::req_type           item,
   input  logic [pwlc_pkg::TRIM_W-1:0] trim,
   output pwlc_pkg::tx_status_type     status
);
   import pwlc_pkg::*;

   localparam int PTR_W = $clog2(TX_DEPTH);
   localparam int CNT_W = $clog2(TX_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TX_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TX_DEPTH);

   typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW} phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] low;
      logic [TICK_W-1:0] high;
   } entry_type;

   entry_type queue_mem [TX_DEPTH];

   phase_type         phase_ff, phase_in, ph;
   logic [TICK_W-1:0] rem_ff, rem_in, rem;
   logic [TICK_W-1:0] low_ff, low_in, lowt;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   entry_type         head_ff, wr_entry;
   logic              tick, wr_en, pop, line;

   always_comb begin
      tick  = fire && (item.op == OP_TICK);
      wr_en = fire && (item.op == OP_ENQUEUE) && (count_ff != FULL_CNT);

      wr_entry.low  = item.low_ticks;
      wr_entry.high = (item.high_ticks > {{(TICK_W-TRIM_W){1'b0}}, trim})
                      ? item.high_ticks - {{(TICK_W-TRIM_W){1'b0}}, trim} : '0;

      ph   = phase_ff;
      rem  = rem_ff;
      lowt = low_ff;
      pop  = 1'b0;
      if (ph == PH_LOW && rem == '0) ph = PH_IDLE;
      if (ph == PH_IDLE && count_ff != '0) begin
         pop  = 1'b1;
         ph   = PH_HIGH;
         rem  = head_ff.high;
         lowt = head_ff.low;
      end
      if (ph == PH_HIGH && rem == '0) begin
         ph  = PH_LOW;
         rem = lowt;
      end
      if (ph == PH_LOW && rem == '0) ph = PH_IDLE;
      line = (ph == PH_HIGH);
      if (ph != PH_IDLE && rem != '0) rem = rem - 1'b1;

      phase_in  = tick ? ph : phase_ff;
      rem_in    = tick ? rem : rem_ff;
      low_in    = tick ? lowt : low_ff;
      pop       = pop && tick;

      rd_ptr_in = rd_ptr_ff;
      if (pop) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff;
      if (wr_en) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;

      count_in = count_ff;
      if (wr_en) count_in = count_ff + 1'b1;
      else if (pop) count_in = count_ff - 1'b1;

      status.line_out = tick ? line : (phase_ff == PH_HIGH);
      status.accepted = wr_en;
      status.busy     = (phase_in != PH_IDLE);
      status.level    = LEVEL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (wr_en) queue_mem[wr_ptr_ff] <= wr_entry;
   end

   // head word prefetch, bypassing a write into the slot about to be read
   always_ff @(posedge clock) begin
      if (wr_en && wr_ptr_ff == rd_ptr_in) head_ff <= wr_entry;
      else head_ff <= queue_mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         rem_ff    <= '0;
         low_ff    <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         low_ff    <= low_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/pwlc_rx.sv -----
// Receive pulse width measurement and symbol classification.
module pwlc_rx (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  pwlc_pkg::req_type        item,
   input  pwlc_pkg::bounds_type     bounds,
   output pwlc_pkg::rx_result_type  result
);
   import pwlc_pkg::*;

   logic              last_ff, last_in;
   logic              meas_ff, meas_in;
   logic [TICK_W-1:0] count_ff, count_in;
   logic              tick;

   function automatic logic in_win(input logic [TICK_W-1:0] w, input window_type win);
      return (w >= win.lo) && ({1'b0, w} <= win.hi);
   endfunction

   always_comb begin
      tick     = fire && (item.op == OP_TICK);
      last_in  = last_ff;
      meas_in  = meas_ff;
      count_in = count_ff;
      result   = '0;
      if (tick) begin
         last_in = item.line_in;
         if (item.line_in) begin
            if (!last_ff) begin
               meas_in  = 1'b1;
               count_in = TICK_W'(1);
            end else if (meas_ff && count_ff != WIDTH_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else if (last_ff && meas_ff) begin
            meas_in      = 1'b0;
            result.valid = 1'b1;
            result.width = count_ff;
            if (in_win(count_ff, bounds.zero_win)) result.symbol = SYM_ZERO;
            else if (in_win(count_ff, bounds.one_win)) result.symbol = SYM_ONE;
            else if (in_win(count_ff, bounds.reset_win)) result.symbol = SYM_RESET;
            else result.symbol = SYM_ERROR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= 1'b0;
         meas_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         last_ff  <= last_in;
         meas_ff  <= meas_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/pulse_width_line_codec_top.sv -----
// Pulse-width line codec top level: input stage, tx/rx units, result stage.
// Each word is one tick (line sample in, line level out) or one enqueue of a
// pulse into the TX_DEPTH-deep transmit queue. A word is taken into an input
// register, processed combinationally against the transmit generator and
// receive measurement state, and its result word lands in an output register,
// so one word per clock is sustained while rsp_stall is low. The result
// register lets the next word be taken while a finished result waits on
// rsp_stall. Window bounds are derived from the configuration registers and
// held in registers alongside them.
module pulse_width_line_codec_top #(
   parameter int TX_DEPTH = pwlc_pkg::DEFAULT_TX_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pwlc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pwlc_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [pwlc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pwlc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pwlc_pkg::*;

   logic          in_vld_ff, in_vld_in;
   req_type       in_data_ff;
   logic          out_vld_ff, out_vld_in;
   rsp_type       out_data_ff, out_data_in;
   logic          fire, take;
   logic [TRIM_W-1:0] trim;
   bounds_type    bounds;
   tx_status_type tx_status;
   rx_result_type rx_result;

   pwlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .trim      (trim),
      .bounds    (bounds)
   );

   pwlc_tx #(.TX_DEPTH(TX_DEPTH)) u_tx (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .trim   (trim),
      .status (tx_status)
   );

   pwlc_rx u_rx (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .bounds (bounds),
      .result (rx_result)
   );

   always_comb begin
      fire      = in_vld_ff && (!out_vld_ff || !rsp_stall);
      req_stall = in_vld_ff && !fire;
      take      = req_valid && !req_stall;
      in_vld_in = take || (in_vld_ff && !fire);
      out_vld_in = fire || (out_vld_ff && rsp_stall);

      out_data_in.line_out         = tx_status.line_out;
      out_data_in.rx_valid         = rx_result.valid;
      out_data_in.rx_symbol        = rx_result.symbol;
      out_data_in.pulse_width      = rx_result.width;
      out_data_in.enqueue_accepted = tx_status.accepted;
      out_data_in.tx_busy          = tx_status.busy;
      out_data_in.queue_level      = tx_status.level;
   end

   always_ff @(posedge clock) begin
      if (take) in_data_ff <= req_data;
      if (fire) out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- design/pwlc_checker.sv -----
// Port-level checks for the pulse-width line codec, bound to the top level.
module pwlc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pwlc_pkg::rsp_type rsp_data
);
   import pwlc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_rx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.rx_valid |->
         rsp_data.rx_symbol == SYM_ZERO && rsp_data.pulse_width == '0)
      else $error("symbol or width set without a received pulse");

   a_enq_no_rx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.enqueue_accepted |-> !rsp_data.rx_valid)
      else $error("enqueue word reported a received pulse");

   a_line_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_out |-> rsp_data.tx_busy)
      else $error("line high while generator idle");

   a_width_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_valid |-> rsp_data.pulse_width != '0)
      else $error("received pulse of zero width");

endmodule

bind pulse_width_line_codec_top pwlc_checker u_pwlc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/tb_pulse_width_line_codec_top.sv -----
// Testbench for the pulse-width line codec: directed and random words checked against a local model.
module tb_pulse_width_line_codec_top;
   import pwlc_pkg::*;

   localparam int TX_DEPTH = DEFAULT_TX_DEPTH;
   localparam int PTR_W = $clog2(TX_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TX_DEPTH - 1);
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_WORDS = 350;
   localparam int RANDOM_PHASES = 5;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum logic [1:0] {TX_IDLE, TX_HIGH, TX_LOW} tx_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // model state
   logic [TICK_W-1:0] cfg_zero_high = ZERO_HIGH_RST;
   logic [TICK_W-1:0] cfg_one_high = ONE_HIGH_RST;
   logic [TICK_W-1:0] cfg_reset_high = RESET_HIGH_RST;
   logic [TICK_W-1:0] cfg_tol_below = TOL_BELOW_RST;
   logic [TICK_W-1:0] cfg_tol_above = TOL_ABOVE_RST;
   logic [TICK_W-1:0] cfg_reset_tol = RESET_TOL_RST;
   logic [TRIM_W-1:0] cfg_trim = TX_TRIM_RST;
   logic [31:0]       tx_queue [TX_DEPTH];
   logic [PTR_W-1:0]  q_rd = '0;
   logic [PTR_W-1:0]  q_wr = '0;
   int                q_cnt = 0;
   tx_state_type      tx_phase = TX_IDLE;
   logic [TICK_W-1:0] tx_left = '0;
   logic [TICK_W-1:0] tx_low_len = '0;
   logic              rx_prev = 1'b0;
   logic              rx_active = 1'b0;
   logic [TICK_W-1:0] rx_count = '0;

   rsp_type awaited_rsp [$];
   logic    last_line_out = 1'b0;
   bit      idle_on = 1'b1;
   int      stall_left = 0;
   int      words_sent = 0;
   int      error_count = 0;
   int      quiet_cycles = 0;

   pulse_width_line_codec_top #(.TX_DEPTH(TX_DEPTH)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit in_win(int w, int nom, int below, int above);
      int lo;
      lo = (nom > below) ? nom - below : 0;
      return (w >= lo) && (w <= nom + above);
   endfunction

   function automatic logic [1:0] pulse_symbol(logic [TICK_W-1:0] w);
      if (in_win(int'(w), int'(cfg_zero_high), int'(cfg_tol_below), int'(cfg_tol_above)))
         return SYM_ZERO;
      if (in_win(int'(w), int'(cfg_one_high), int'(cfg_tol_below), int'(cfg_tol_above)))
         return SYM_ONE;
      if (in_win(int'(w), int'(cfg_reset_high), int'(cfg_reset_tol), int'(cfg_reset_tol)))
         return SYM_RESET;
      return SYM_ERROR;
   endfunction

   function automatic rsp_type codec_response(req_type w);
      rsp_type r;
      logic [TICK_W-1:0] h;
      r = '0;
      if (w.op == OP_ENQUEUE) begin
         if (q_cnt < TX_DEPTH) begin
            h = (w.high_ticks > TICK_W'(cfg_trim)) ? w.high_ticks - TICK_W'(cfg_trim) : '0;
            tx_queue[q_wr] = {w.low_ticks, h};
            q_wr = (q_wr == LAST_PTR) ? '0 : q_wr + 1'b1;
            q_cnt++;
            r.enqueue_accepted = 1'b1;
         end
         r.line_out = (tx_phase == TX_HIGH);
      end else begin
         if (tx_phase == TX_LOW && tx_left == 0) tx_phase = TX_IDLE;
         if (tx_phase == TX_IDLE && q_cnt > 0) begin
            tx_left = tx_queue[q_rd][15:0];
            tx_low_len = tx_queue[q_rd][31:16];
            q_rd = (q_rd == LAST_PTR) ? '0 : q_rd + 1'b1;
            q_cnt--;
            tx_phase = TX_HIGH;
         end
         if (tx_phase == TX_HIGH && tx_left == 0) begin
            tx_phase = TX_LOW;
            tx_left = tx_low_len;
         end
         if (tx_phase == TX_LOW && tx_left == 0) tx_phase = TX_IDLE;
         r.line_out = (tx_phase == TX_HIGH);
         if (tx_phase != TX_IDLE && tx_left > 0) tx_left--;

         if (w.line_in) begin
            if (!rx_prev) begin
               rx_active = 1'b1;
               rx_count = TICK_W'(1);
            end else if (rx_active && rx_count != WIDTH_MAX) begin
               rx_count++;
            end
         end else if (rx_prev && rx_active) begin
            r.rx_valid = 1'b1;
            r.pulse_width = rx_count;
            r.rx_symbol = pulse_symbol(rx_count);
            rx_active = 1'b0;
         end
         rx_prev = w.line_in;
      end
      r.tx_busy = (tx_phase != TX_IDLE);
      r.queue_level = q_cnt[LEVEL_W-1:0];
      return r;
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      rsp_type want;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = codec_response(w);
      last_line_out = want.line_out;
      awaited_rsp.push_back(want);
      words_sent++;
   endtask

   task automatic tick(input logic line);
      req_type w;
      w.op = OP_TICK;
      w.line_in = line;
      w.high_ticks = TICK_W'($urandom);
      w.low_ticks = TICK_W'($urandom);
      send_word(w);
   endtask

   task automatic enqueue(input logic [TICK_W-1:0] hi, input logic [TICK_W-1:0] lo);
      req_type w;
      w.op = OP_ENQUEUE;
      w.line_in = 1'($urandom_range(0, 1));
      w.high_ticks = hi;
      w.low_ticks = lo;
      send_word(w);
   endtask

   // full-range fields only when the word will be dropped
   task automatic enqueue_random();
      if (q_cnt >= TX_DEPTH) enqueue(TICK_W'($urandom), TICK_W'($urandom));
      else enqueue(TICK_W'($urandom_range(0, 24)), TICK_W'($urandom_range(0, 12)));
   endtask

   task automatic rx_pulse(input int width, input int low_len, input bit mix_tx);
      for (int i = 0; i < width; i++) begin
         if (mix_tx && $urandom_range(0, 7) == 0) enqueue_random();
         tick(1'b1);
      end
      repeat (low_len) tick(1'b0);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_ZERO_HIGH: cfg_zero_high = val;
         REG_ONE_HIGH: cfg_one_high = val;
         REG_RESET_HIGH: cfg_reset_high = val;
         REG_TOL_BELOW: cfg_tol_below = val;
         REG_TOL_ABOVE: cfg_tol_above = val;
         REG_RESET_TOL: cfg_reset_tol = val;
         REG_TX_TRIM: cfg_trim = val[TRIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input int z, input int o, input int r, input int tb,
                               input int ta, input int rt, input int trim);
      settle();
      write_reg(REG_ZERO_HIGH, CSR_DATA_W'(z));
      write_reg(REG_ONE_HIGH, CSR_DATA_W'(o));
      write_reg(REG_RESET_HIGH, CSR_DATA_W'(r));
      write_reg(REG_TOL_BELOW, CSR_DATA_W'(tb));
      write_reg(REG_TOL_ABOVE, CSR_DATA_W'(ta));
      write_reg(REG_RESET_TOL, CSR_DATA_W'(rt));
      write_reg(REG_TX_TRIM, CSR_DATA_W'(trim));
      write_reg(REG_UNUSED, CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_line_high_after_reset();
      tick(1'b1);
      tick(1'b1);
      tick(1'b0);
   endtask

   // fills the queue with zero-length and over-trimmed pulses, overflows it, then ticks until it drains
   task automatic test_queue_full();
      enqueue(16'd0, 16'd0);
      enqueue(16'd2, 16'd1);
      enqueue(16'd3, 16'd0);
      enqueue(16'd5, 16'd2);
      enqueue(16'd0, 16'd0);
      enqueue(16'd4, 16'd0);
      enqueue(16'd1, 16'd1);
      enqueue(16'd6, 16'd1);
      enqueue(16'hFFFF, 16'hFFFF);
      while (q_cnt != 0 || tx_phase != TX_IDLE) tick(last_line_out);
   endtask

   // zero window floors at 0 and overlaps the one window
   task automatic test_window_bounds();
      apply_config(1, 6, 14, 5, 1, 2, 0);
      rx_pulse(2, 1, 1'b0);
      rx_pulse(8, 1, 1'b0);
      rx_pulse(12, 1, 1'b0);
   endtask

   // upper bounds above 65535 must not wrap
   task automatic test_window_no_wrap();
      apply_config(16'hFFF0, 16'hFFF8, 16'hFFFF, 16'hFFF0, 16'h0020, 16'h0010, 0);
      rx_pulse(20, 1, 1'b0);
      rx_pulse(3, 1, 1'b0);
   endtask

   task automatic test_random_traffic();
      int target;
      int n;
      int sel;
      int nom;
      int below;
      int above;
      int width;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase != 1);
         if (phase == 2) begin
            apply_config(0, 0, 0, 0, 0, 0, 0);
         end else begin
            n = $urandom_range(1, 12);
            apply_config(n, n + $urandom_range(2, 15), $urandom_range(20, 60),
                         $urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 6),
                         (phase == 3) ? 255 : $urandom_range(0, 6));
         end
         target = words_sent + RANDOM_WORDS;
         while (words_sent < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  sel = $urandom_range(0, 2);
                  nom = int'((sel == 0) ? cfg_zero_high :
                             (sel == 1) ? cfg_one_high : cfg_reset_high);
                  below = int'((sel == 2) ? cfg_reset_tol : cfg_tol_below);
                  above = int'((sel == 2) ? cfg_reset_tol : cfg_tol_above);
                  width = nom - below - 1 + $urandom_range(0, below + above + 2);
                  if (width < 1) width = 1;
                  if (width > 400) width = 400;
                  rx_pulse(width, $urandom_range(1, 4), 1'b1);
               end
               4, 5, 6: begin
                  n = $urandom_range(1, 4);
                  repeat (n) enqueue_random();
                  n = $urandom_range(10, 40);
                  repeat (n) tick(last_line_out);
               end
               7: begin
                  while (q_cnt < TX_DEPTH) enqueue_random();
                  enqueue_random();
                  n = $urandom_range(5, 30);
                  repeat (n) tick(last_line_out);
               end
               default: begin
                  n = $urandom_range(5, 20);
                  repeat (n) begin
                     if ($urandom_range(0, 1)) tick(1'($urandom_range(0, 1)));
                     else enqueue_random();
                  end
               end
            endcase
         end
      end
   endtask

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_data);
         end else begin
            want = awaited_rsp.pop_front();
            check_field("line_out", 32'(want.line_out), 32'(rsp_data.line_out));
            check_field("rx_valid", 32'(want.rx_valid), 32'(rsp_data.rx_valid));
            check_field("rx_symbol", 32'(want.rx_symbol), 32'(rsp_data.rx_symbol));
            check_field("pulse_width", 32'(want.pulse_width), 32'(rsp_data.pulse_width));
            check_field("enqueue_accepted", 32'(want.enqueue_accepted),
                        32'(rsp_data.enqueue_accepted));
            check_field("tx_busy", 32'(want.tx_busy), 32'(rsp_data.tx_busy));
            check_field("queue_level", 32'(want.queue_level), 32'(rsp_data.queue_level));
         end
         stall_left = idle_on ? $urandom_range(0, 19) : 0;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_line_high_after_reset();
      test_queue_full();
      test_window_bounds();
      test_window_no_wrap();
      test_random_traffic();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
